/* rtl/core/bphr_pkg.sv */
// Package: shared types, register indexes and reset values for the button event unit.
`timescale 1ns / 1ps
`default_nettype none

package bphr_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int FIELD_TIME_W  = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int EVT_EN_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LOW         = 3'd0,
        CFG_PRESS_DELAY        = 3'd1,
        CFG_RELEASE_DELAY      = 3'd2,
        CFG_HOLD_TIME          = 3'd3,
        CFG_HOLD_WAITS_RELEASE = 3'd4,
        CFG_REPEAT_INTERVAL    = 3'd5,
        CFG_EVENT_ENABLE       = 3'd6
    } t_cfg_idx;

    localparam int EN_PRESS   = 0;
    localparam int EN_RELEASE = 1;
    localparam int EN_HOLD    = 2;
    localparam int EN_REPEAT  = 3;

    localparam logic                    RST_ACTIVE_LOW         = 1'b1;
    localparam logic [FIELD_TIME_W-1:0] RST_PRESS_DELAY        = 32'd0;
    localparam logic [FIELD_TIME_W-1:0] RST_RELEASE_DELAY      = 32'd0;
    localparam logic [FIELD_TIME_W-1:0] RST_HOLD_TIME          = 32'd1000;
    localparam logic                    RST_HOLD_WAITS_RELEASE = 1'b0;
    localparam logic [FIELD_TIME_W-1:0] RST_REPEAT_INTERVAL    = 32'd100;
    localparam logic [EVT_EN_W-1:0]     RST_EVENT_ENABLE       = 4'd0;

    typedef struct packed {
        logic                    active_low;
        logic [FIELD_TIME_W-1:0] press_delay;
        logic [FIELD_TIME_W-1:0] release_delay;
        logic [FIELD_TIME_W-1:0] hold_time;
        logic                    hold_waits_release;
        logic [FIELD_TIME_W-1:0] repeat_interval;
        logic [EVT_EN_W-1:0]     event_enable;
    } t_cfg;

    typedef struct packed {
        logic seeded;
        logic last_level;
        logic press_done;
        logic release_done;
        logic hold_qualified;
        logic hold_done;
    } t_flags;

    localparam t_flags FLAGS_RST = '{
        seeded:         1'b0,
        last_level:     1'b0,
        press_done:     1'b0,
        release_done:   1'b1,
        hold_qualified: 1'b0,
        hold_done:      1'b0
    };

    typedef struct packed {
        logic pressed;
        logic press_event;
        logic release_event;
        logic hold_event;
        logic repeat_event;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/bphr_if.sv */
// Interfaces: poll input channel and event result channel.
`timescale 1ns / 1ps
`default_nettype none

interface bphr_in_if;
    logic        valid;
    logic        ready;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bphr_out_if;
    logic valid;
    logic ready;
    logic pressed;
    logic press_event;
    logic release_event;
    logic hold_event;
    logic repeat_event;

    modport source (output valid, output pressed, output press_event, output release_event,
                    output hold_event, output repeat_event, input ready);
    modport sink   (input valid, input pressed, input press_event, input release_event,
                    input hold_event, input repeat_event, output ready);
endinterface

`default_nettype wire

/* rtl/core/bphr_cfg_regs.sv */
// Configuration register file with write port.
`timescale 1ns / 1ps
`default_nettype none

module bphr_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bphr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bphr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bphr_pkg::t_cfg                  o_cfg
);
    import bphr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ACTIVE_LOW:         n_cfg.active_low         = i_cfg_data[0];
                CFG_PRESS_DELAY:        n_cfg.press_delay        = i_cfg_data[FIELD_TIME_W-1:0];
                CFG_RELEASE_DELAY:      n_cfg.release_delay      = i_cfg_data[FIELD_TIME_W-1:0];
                CFG_HOLD_TIME:          n_cfg.hold_time          = i_cfg_data[FIELD_TIME_W-1:0];
                CFG_HOLD_WAITS_RELEASE: n_cfg.hold_waits_release = i_cfg_data[0];
                CFG_REPEAT_INTERVAL:    n_cfg.repeat_interval    = i_cfg_data[FIELD_TIME_W-1:0];
                CFG_EVENT_ENABLE:       n_cfg.event_enable       = i_cfg_data[EVT_EN_W-1:0];
                default:                n_cfg                    = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low         <= RST_ACTIVE_LOW;
            r_cfg.press_delay        <= RST_PRESS_DELAY;
            r_cfg.release_delay      <= RST_RELEASE_DELAY;
            r_cfg.hold_time          <= RST_HOLD_TIME;
            r_cfg.hold_waits_release <= RST_HOLD_WAITS_RELEASE;
            r_cfg.repeat_interval    <= RST_REPEAT_INTERVAL;
            r_cfg.event_enable       <= RST_EVENT_ENABLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/core/bphr_event_logic.sv */
// Combinational event logic: edge detect, delay checks and next state for one poll.
`timescale 1ns / 1ps
`default_nettype none

module bphr_event_logic #(
    parameter int TIME_BITS = bphr_pkg::TIME_BITS_DEF
) (
    input  bphr_pkg::t_cfg                     i_cfg,
    input  bphr_pkg::t_flags                   i_flags,
    input  logic [TIME_BITS-1:0]               i_press_stamp,
    input  logic [TIME_BITS-1:0]               i_release_stamp,
    input  logic [TIME_BITS-1:0]               i_repeat_stamp,
    input  logic                               i_pin_level,
    input  logic [bphr_pkg::FIELD_TIME_W-1:0]  i_now_ms,
    output bphr_pkg::t_flags                   o_flags,
    output logic [TIME_BITS-1:0]               o_press_stamp,
    output logic [TIME_BITS-1:0]               o_release_stamp,
    output logic [TIME_BITS-1:0]               o_repeat_stamp,
    output bphr_pkg::t_result                  o_result
);
    import bphr_pkg::*;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] press_dly_t;
    logic [TIME_BITS-1:0] release_dly_t;
    logic [TIME_BITS-1:0] hold_t;
    logic [TIME_BITS-1:0] repeat_t;
    logic                 lvl;

    assign now_t         = TIME_BITS'(i_now_ms);
    assign press_dly_t   = TIME_BITS'(i_cfg.press_delay);
    assign release_dly_t = TIME_BITS'(i_cfg.release_delay);
    assign hold_t        = TIME_BITS'(i_cfg.hold_time);
    assign repeat_t      = TIME_BITS'(i_cfg.repeat_interval);
    assign lvl           = i_cfg.active_low ? !i_pin_level : i_pin_level;

    always_comb begin
        o_flags         = i_flags;
        o_press_stamp   = i_press_stamp;
        o_release_stamp = i_release_stamp;
        o_repeat_stamp  = i_repeat_stamp;
        o_result        = '0;
        o_result.pressed = lvl;

        if (!i_flags.seeded) begin
            o_flags.seeded     = 1'b1;
            o_flags.last_level = lvl;
        end else begin
            if (lvl != i_flags.last_level) begin
                if (lvl) begin
                    o_press_stamp          = now_t;
                    o_repeat_stamp         = now_t;
                    o_flags.press_done     = 1'b0;
                    o_flags.hold_done      = 1'b0;
                    o_flags.hold_qualified = 1'b0;
                end else begin
                    o_release_stamp      = now_t;
                    o_flags.release_done = 1'b0;
                    // deferred hold fires on the release edge
                    if (i_flags.hold_qualified && i_cfg.hold_waits_release
                        && !i_flags.hold_done) begin
                        o_flags.hold_done   = 1'b1;
                        o_result.hold_event = i_cfg.event_enable[EN_HOLD];
                    end
                end
                o_flags.last_level = lvl;
            end

            if (lvl) begin
                if (!o_flags.press_done && ((now_t - o_press_stamp) >= press_dly_t)) begin
                    o_flags.press_done   = 1'b1;
                    o_result.press_event = i_cfg.event_enable[EN_PRESS];
                end
                if (!o_flags.hold_qualified && ((now_t - o_press_stamp) >= hold_t)) begin
                    o_flags.hold_qualified = 1'b1;
                    if (!i_cfg.hold_waits_release && !o_flags.hold_done) begin
                        o_flags.hold_done   = 1'b1;
                        o_result.hold_event = i_cfg.event_enable[EN_HOLD];
                    end
                end
                if (i_cfg.event_enable[EN_REPEAT]
                    && ((now_t - o_repeat_stamp) >= repeat_t)) begin
                    o_repeat_stamp        = now_t;
                    o_result.repeat_event = 1'b1;
                end
            end else begin
                if (!o_flags.release_done
                    && ((now_t - o_release_stamp) >= release_dly_t)) begin
                    o_flags.release_done   = 1'b1;
                    o_result.release_event = i_cfg.event_enable[EN_RELEASE];
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/button_press_hold_repeat_events_unit.sv */
// Top level: button press/release/hold/repeat event unit.
//
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    pin_level, now_ms
//  o_out     out  valid / ready    pressed, press/release/hold/repeat_event
//  i_cfg_*   in   write enable     i_cfg_idx, i_cfg_data
//
// One poll per cycle sustained while results are taken; a poll's result is registered in the result register.
// Input register -> event logic -> result register; button state updates as a poll
// moves into the result register, so back-to-back polls see each other's state.
// Synchronous active-low reset clears valid flags, resets button state and stamps, and loads config reset values.
// A stalled result holds; the input register keeps taking polls while it has room.
`timescale 1ns / 1ps
`default_nettype none

module button_press_hold_repeat_events_unit #(
    parameter int TIME_BITS = bphr_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bphr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bphr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bphr_in_if.sink                         i_in,
    bphr_out_if.source                      o_out
);
    import bphr_pkg::*;

    t_cfg                    cfg;
    logic                    r_in_valid;
    logic                    r_in_pin;
    logic [FIELD_TIME_W-1:0] r_in_now;
    logic                    r_out_valid;
    t_result                 r_res;
    t_result                 n_res;
    t_flags                  r_flags;
    t_flags                  n_flags;
    logic [TIME_BITS-1:0]    r_press_stamp;
    logic [TIME_BITS-1:0]    r_release_stamp;
    logic [TIME_BITS-1:0]    r_repeat_stamp;
    logic [TIME_BITS-1:0]    n_press_stamp;
    logic [TIME_BITS-1:0]    n_release_stamp;
    logic [TIME_BITS-1:0]    n_repeat_stamp;
    logic                    advance;
    logic                    in_take;

    bphr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bphr_event_logic #(
        .TIME_BITS (TIME_BITS)
    ) u_logic (
        .i_cfg           (cfg),
        .i_flags         (r_flags),
        .i_press_stamp   (r_press_stamp),
        .i_release_stamp (r_release_stamp),
        .i_repeat_stamp  (r_repeat_stamp),
        .i_pin_level     (r_in_pin),
        .i_now_ms        (r_in_now),
        .o_flags         (n_flags),
        .o_press_stamp   (n_press_stamp),
        .o_release_stamp (n_release_stamp),
        .o_repeat_stamp  (n_repeat_stamp),
        .o_result        (n_res)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pin <= i_in.pin_level;
            r_in_now <= i_in.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags         <= FLAGS_RST;
            r_press_stamp   <= '0;
            r_release_stamp <= '0;
            r_repeat_stamp  <= '0;
        end else if (advance) begin
            r_flags         <= n_flags;
            r_press_stamp   <= n_press_stamp;
            r_release_stamp <= n_release_stamp;
            r_repeat_stamp  <= n_repeat_stamp;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pressed       = r_res.pressed;
    assign o_out.press_event   = r_res.press_event;
    assign o_out.release_event = r_res.release_event;
    assign o_out.hold_event    = r_res.hold_event;
    assign o_out.repeat_event  = r_res.repeat_event;

endmodule

`default_nettype wire

/* rtl/core/bphr_checker.sv */
// Port-level checker for the button event unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bphr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_pressed,
    input logic i_press_event,
    input logic i_release_event,
    input logic i_hold_event,
    input logic i_repeat_event
);

    // no result can appear in the cycle right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // press and repeat only fire while pressed, release only while released
    a_level_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((!i_press_event && !i_repeat_event) || i_pressed)
                        && (!i_release_event || !i_pressed))
        else $error("event inconsistent with pressed level");

    // press and release never share a poll
    a_press_release_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_press_event && i_release_event))
        else $error("press and release event in one transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pressed)
            && $stable(i_press_event) && $stable(i_release_event)
            && $stable(i_hold_event) && $stable(i_repeat_event))
        else $error("stalled result changed");

endmodule

bind button_press_hold_repeat_events_unit bphr_checker u_bphr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_pressed       (o_out.pressed),
    .i_press_event   (o_out.press_event),
    .i_release_event (o_out.release_event),
    .i_hold_event    (o_out.hold_event),
    .i_repeat_event  (o_out.repeat_event)
);

`default_nettype wire
